/* sv/utf8v_pkg.sv */
// Package for the UTF-8 sequence validator: byte-range constants, lead-byte
// kinds and the classified word that travels from the front part to the back part.
// No dependencies.
package utf8v_pkg;

  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] CONT_MIN   = 8'h80;
  localparam logic [7:0] CONT_8_MAX = 8'h8F;
  localparam logic [7:0] CONT_9_MIN = 8'h90;
  localparam logic [7:0] CONT_9_MAX = 8'h9F;
  localparam logic [7:0] CONT_A_MIN = 8'hA0;
  localparam logic [7:0] CONT_MAX   = 8'hBF;
  localparam logic [7:0] LEAD2_MIN  = 8'hC2;
  localparam logic [7:0] LEAD2_MAX  = 8'hDF;
  localparam logic [7:0] LEAD_E0    = 8'hE0;
  localparam logic [7:0] LEAD_ED    = 8'hED;
  localparam logic [7:0] LEAD3_MAX  = 8'hEF;
  localparam logic [7:0] LEAD_F0    = 8'hF0;
  localparam logic [7:0] LEAD_F4    = 8'hF4;

  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [2:0] {
    LK_OTHER,
    LK_E0,
    LK_ED,
    LK_F0,
    LK_F4
  } lead_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
    logic [2:0] lead_len;
    lead_kind_t lead_kind;
    logic       cont_8x;
    logic       cont_9x;
    logic       cont_ab;
  } item_t;

endpackage

/* sv/utf8v_front.sv */
// Front part of the UTF-8 sequence validator: accepts input words and classifies
// each byte as a lead byte and as a continuation byte, holding the result in one register.
// Depends on utf8v_pkg.
module utf8v_front import utf8v_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       item_valid,
  input  logic       item_ready,
  output item_t      item
);

  logic  valid_r;
  item_t item_r;
  item_t item_nxt;

  assign in_ready   = !valid_r || item_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    item_nxt             = '0;
    item_nxt.data_byte   = in_byte;
    item_nxt.end_of_text = in_last;
    if (in_byte <= ASCII_MAX) begin
      item_nxt.lead_len = 3'd1;
    end else if (in_byte >= LEAD2_MIN && in_byte <= LEAD2_MAX) begin
      item_nxt.lead_len = 3'd2;
    end else if (in_byte >= LEAD_E0 && in_byte <= LEAD3_MAX) begin
      item_nxt.lead_len = 3'd3;
    end else if (in_byte >= LEAD_F0 && in_byte <= LEAD_F4) begin
      item_nxt.lead_len = 3'd4;
    end else begin
      item_nxt.lead_len = 3'd0;
    end
    case (in_byte)
      LEAD_E0: item_nxt.lead_kind = LK_E0;
      LEAD_ED: item_nxt.lead_kind = LK_ED;
      LEAD_F0: item_nxt.lead_kind = LK_F0;
      LEAD_F4: item_nxt.lead_kind = LK_F4;
      default: item_nxt.lead_kind = LK_OTHER;
    endcase
    item_nxt.cont_8x = (in_byte >= CONT_MIN) && (in_byte <= CONT_8_MAX);
    item_nxt.cont_9x = (in_byte >= CONT_9_MIN) && (in_byte <= CONT_9_MAX);
    item_nxt.cont_ab = (in_byte >= CONT_A_MIN) && (in_byte <= CONT_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

/* sv/utf8v_queue.sv */
// Two-entry queue of classified bytes between the front and back parts of the
// UTF-8 sequence validator, so that each side may stall on its own.
// Depends on utf8v_pkg.
module utf8v_queue import utf8v_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  item_t      slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* sv/utf8v_back.sv */
// Back part of the UTF-8 sequence validator: keeps the open sequence, checks
// each classified byte against it and holds the result word in an output register.
// Depends on utf8v_pkg.
module utf8v_back import utf8v_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [31:0] res_packed,
  output logic [2:0]  res_length,
  output logic        res_error
);

  logic [2:0]  exp_len_r;
  logic [2:0]  exp_len_nxt;
  logic [1:0]  seen_r;
  logic [1:0]  seen_nxt;
  logic [23:0] partial_r;
  logic [23:0] partial_nxt;
  lead_kind_t  kind_r;
  lead_kind_t  kind_nxt;

  logic        out_valid_r;
  logic [31:0] out_packed_r;
  logic [2:0]  out_len_r;
  logic        out_err_r;

  logic        emit;
  logic [31:0] emit_packed;
  logic [2:0]  emit_len;
  logic        emit_err;
  logic        take;
  logic        cont_ok;
  logic [31:0] joined;
  logic [2:0]  count;

  assign item_ready = !out_valid_r || res_ready;
  assign take       = item_valid && item_ready;
  assign res_valid  = out_valid_r;
  assign res_packed = out_packed_r;
  assign res_length = out_len_r;
  assign res_error  = out_err_r;
  assign count      = {1'b0, seen_r} + 3'd1;

  always_comb begin
    case (seen_r)
      2'd1:    joined = {8'd0, partial_r} | {16'd0, item.data_byte, 8'd0};
      2'd2:    joined = {8'd0, partial_r} | {8'd0, item.data_byte, 16'd0};
      2'd3:    joined = {8'd0, partial_r} | {item.data_byte, 24'd0};
      default: joined = {8'd0, partial_r};
    endcase
  end

  always_comb begin
    cont_ok = item.cont_8x || item.cont_9x || item.cont_ab;
    if (seen_r == 2'd1) begin
      case (kind_r)
        LK_E0:   cont_ok = item.cont_ab;
        LK_ED:   cont_ok = item.cont_8x || item.cont_9x;
        LK_F0:   cont_ok = item.cont_9x || item.cont_ab;
        LK_F4:   cont_ok = item.cont_8x;
        default: cont_ok = item.cont_8x || item.cont_9x || item.cont_ab;
      endcase
    end
  end

  always_comb begin
    exp_len_nxt = exp_len_r;
    seen_nxt    = seen_r;
    partial_nxt = partial_r;
    kind_nxt    = kind_r;
    emit        = 1'b0;
    emit_packed = '0;
    emit_len    = 3'd0;
    emit_err    = 1'b1;
    if (exp_len_r == 3'd0) begin
      if (item.lead_len == 3'd0) begin
        emit = 1'b1;
      end else if (item.lead_len == 3'd1) begin
        emit        = 1'b1;
        emit_packed = {24'd0, item.data_byte};
        emit_len    = 3'd1;
        emit_err    = 1'b0;
      end else if (item.end_of_text) begin
        emit = 1'b1;
      end else begin
        exp_len_nxt = item.lead_len;
        seen_nxt    = 2'd1;
        partial_nxt = {16'd0, item.data_byte};
        kind_nxt    = item.lead_kind;
      end
    end else if (seen_r == 2'd0 || {1'b0, seen_r} >= exp_len_r || !cont_ok) begin
      emit = 1'b1;
    end else if (count == exp_len_r) begin
      emit        = 1'b1;
      emit_packed = joined;
      emit_len    = count;
      emit_err    = 1'b0;
    end else if (item.end_of_text) begin
      emit = 1'b1;
    end else begin
      partial_nxt = joined[23:0];
      seen_nxt    = count[1:0];
    end
    if (emit) begin
      exp_len_nxt = 3'd0;
      seen_nxt    = 2'd0;
      partial_nxt = '0;
      kind_nxt    = LK_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r   <= 3'd0;
      seen_r      <= 2'd0;
      partial_r   <= '0;
      kind_r      <= LK_OTHER;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        exp_len_r <= exp_len_nxt;
        seen_r    <= seen_nxt;
        partial_r <= partial_nxt;
        kind_r    <= kind_nxt;
      end
      if (take && emit) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_packed_r <= emit_packed;
      out_len_r    <= emit_len;
      out_err_r    <= emit_err;
    end
  end

endmodule

/* sv/utf8_sequence_validator_top.sv */
// Top level of the UTF-8 sequence validator: front classifier, two-entry queue
// and back sequence checker. Depends on utf8v_pkg, utf8v_front, utf8v_queue, utf8v_back.
//
// The block takes one byte of UTF-8 text per word and sustains one word per
// cycle while the receiver does not stall the output. A result word for the byte
// that completes a sequence or reveals an error passes the front classifier register,
// a queue slot and the back output register; the back part's update of the open
// sequence sets the rate. Bytes inside an unfinished sequence give no result.
// An error result carries zero bytes, zero length and the error flag in tuser.
module utf8_sequence_validator_top import utf8v_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // data_byte[7:0]
  input  logic                   in_tlast,   // end_of_text
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // packed_bytes[31:0], sequence_length[34:32], zeros
  output logic                   out_tuser   // is_error
);

  logic        front_valid;
  logic        front_ready;
  item_t       front_item;
  logic        queue_valid;
  logic        queue_ready;
  item_t       queue_item;
  logic [31:0] res_packed;
  logic [2:0]  res_length;
  logic        res_error;

  utf8v_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  utf8v_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_item   (queue_item)
  );

  utf8v_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (queue_valid),
    .item_ready (queue_ready),
    .item       (queue_item),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_packed (res_packed),
    .res_length (res_length),
    .res_error  (res_error)
  );

  assign out_tdata = {5'd0, res_length, res_packed};
  assign out_tuser = res_error;

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("error result carries non-zero bytes or length");

  a_good_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[34:32] == 3'd1 || out_tdata[34:32] == 3'd2 ||
                                 out_tdata[34:32] == 3'd3 || out_tdata[34:32] == 3'd4)
    else $error("well-formed result has a length outside one to four");

  a_single_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser && out_tdata[34:32] == 3'd1 |->
      out_tdata[31:8] == 24'd0 && !out_tdata[7])
    else $error("one-byte result is not a plain ASCII byte");

endmodule

/* tb/tb.sv */
// Self-checking testbench for utf8_sequence_validator_top: directed and random UTF-8 text,
// with every result word checked against a cycle-free predictor of the sequence checker.
// Depends on utf8v_pkg and the RTL of utf8_sequence_validator_top.
module tb import utf8v_pkg::*; ();

  localparam int IDLE_PERCENT = 11;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;

  typedef struct {
    logic [31:0] seq_bytes;
    logic [2:0]  seq_len;
    logic        err;
  } char_result_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata   = 8'h00;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  char_result_t expected_chars[$];
  logic [2:0]   open_len   = '0;
  logic [1:0]   open_count = '0;
  logic [23:0]  open_bytes = '0;
  int           fail_count = 0;
  int           bytes_sent = 0;
  int           stall_cycles = 0;
  bit           steady   = 1'b0;
  bit           hold_req = 1'b0;

  utf8_sequence_validator_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void cont_bounds(input logic [7:0] lead, input logic [1:0] pos,
                                      output logic [7:0] lo, output logic [7:0] hi);
    lo = CONT_MIN;
    hi = CONT_MAX;
    if (pos == 2'd1) begin
      if (lead == LEAD_E0) lo = CONT_A_MIN;
      else if (lead == LEAD_ED) hi = CONT_9_MAX;
      else if (lead == LEAD_F0) lo = CONT_9_MIN;
      else if (lead == LEAD_F4) hi = CONT_8_MAX;
    end
  endfunction

  task automatic push_char(input logic [31:0] b, input logic [2:0] len, input logic err);
    char_result_t r;
    r.seq_bytes = b;
    r.seq_len   = len;
    r.err       = err;
    expected_chars.push_back(r);
  endtask

  task automatic push_error();
    open_len   = '0;
    open_count = '0;
    open_bytes = '0;
    push_char('0, 3'd0, 1'b1);
  endtask

  // Advances the sequence state by one accepted byte and queues any result it gives.
  task automatic predict_char(input logic [7:0] b, input logic last);
    logic [2:0]  len;
    logic [7:0]  lo, hi;
    logic [31:0] joined;
    logic [2:0]  count;
    if (open_len == 3'd0) begin
      if (b <= ASCII_MAX) len = 3'd1;
      else if (b >= LEAD2_MIN && b <= LEAD2_MAX) len = 3'd2;
      else if (b >= LEAD_E0 && b <= LEAD3_MAX) len = 3'd3;
      else if (b >= LEAD_F0 && b <= LEAD_F4) len = 3'd4;
      else len = 3'd0;
      if (len == 3'd0) push_error();
      else if (len == 3'd1) push_char({24'h0, b}, 3'd1, 1'b0);
      else if (last) push_error();
      else begin
        open_len   = len;
        open_count = 2'd1;
        open_bytes = {16'h0, b};
      end
    end else begin
      cont_bounds(open_bytes[7:0], open_count, lo, hi);
      if (b < lo || b > hi) push_error();
      else begin
        joined = {8'h0, open_bytes} | ({24'h0, b} << (8 * open_count));
        count  = {1'b0, open_count} + 3'd1;
        if (count == open_len) begin
          open_len   = '0;
          open_count = '0;
          open_bytes = '0;
          push_char(joined, count, 1'b0);
        end else if (last) push_error();
        else begin
          open_bytes = joined[23:0];
          open_count = count[1:0];
        end
      end
    end
  endtask

  task automatic send_word(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_char(b, last);
    bytes_sent++;
  endtask

  // One random character, at times corrupted, cut off by end of text or a lone random byte.
  task automatic send_random_char();
    logic [7:0] seq [4];
    logic [7:0] lo, hi;
    int len, cut;
    if ($urandom_range(0, 99) < 10) begin
      send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      return;
    end
    len = $urandom_range(1, 4);
    case (len)
      1: seq[0] = 8'($urandom_range(0, ASCII_MAX));
      2: seq[0] = 8'($urandom_range(LEAD2_MIN, LEAD2_MAX));
      3: seq[0] = 8'($urandom_range(LEAD_E0, LEAD3_MAX));
      default: seq[0] = 8'($urandom_range(LEAD_F0, LEAD_F4));
    endcase
    for (int k = 1; k < len; k++) begin
      cont_bounds(seq[0], 2'(k), lo, hi);
      seq[k] = 8'($urandom_range(lo, hi));
    end
    if ($urandom_range(0, 99) < 12) seq[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
    cut = ($urandom_range(0, 99) < 8) ? $urandom_range(0, len - 1) : len;
    for (int k = 0; k < len && k <= cut; k++) send_word(seq[k], k == cut);
  endtask

  task automatic test_extremes();
    send_word(8'h00, 1'b0);
    send_word(ASCII_MAX, 1'b1);
    send_word(LEAD2_MAX, 1'b0);
    send_word(CONT_MAX, 1'b0);
    send_word(8'hEF, 1'b0);
    send_word(CONT_MIN, 1'b0);
    send_word(CONT_MAX, 1'b1);
  endtask

  task automatic test_narrowed_second_bytes();
    send_word(LEAD_E0, 1'b0);
    send_word(CONT_A_MIN, 1'b0);
    send_word(CONT_MIN, 1'b0);
    send_word(LEAD_E0, 1'b0);
    send_word(CONT_9_MAX, 1'b0);
    send_word(LEAD_ED, 1'b0);
    send_word(CONT_A_MIN, 1'b0);
    send_word(LEAD_F0, 1'b0);
    send_word(CONT_9_MIN, 1'b0);
    send_word(CONT_MIN, 1'b0);
    send_word(CONT_MAX, 1'b0);
    send_word(LEAD_F4, 1'b0);
    send_word(CONT_8_MAX, 1'b0);
    send_word(CONT_MAX, 1'b0);
    send_word(CONT_MIN, 1'b0);
    send_word(LEAD_F4, 1'b0);
    send_word(CONT_9_MIN, 1'b0);
  endtask

  task automatic test_bad_and_truncated();
    send_word(8'hC1, 1'b0);
    send_word(8'hF5, 1'b0);
    send_word(LEAD2_MIN, 1'b1);
    send_word(8'hE1, 1'b0);
    send_word(CONT_MIN, 1'b1);
    send_word(8'hC3, 1'b0);
    send_word(8'h41, 1'b0);
  endtask

  task automatic test_random_text(input int count);
    int target;
    target = bytes_sent + count;
    while (bytes_sent < target) send_random_char();
  endtask

  // The receiver stops for a long stretch while words keep coming, so the input backs up.
  task automatic test_output_backpressure();
    hold_req = 1'b1;
    for (int k = 0; k < 30; k++) send_word(8'($urandom_range(0, ASCII_MAX)), 1'b0);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  always @(posedge clk) begin : check_results
    char_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected result word, got tdata %h tuser %b",
                 $time, out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_tdata[31:0] !== want.seq_bytes) begin
          $display("%0t: sequence bytes expected %h, got %h",
                   $time, want.seq_bytes, out_tdata[31:0]);
          fail_count++;
        end
        if (out_tdata[34:32] !== want.seq_len) begin
          $display("%0t: sequence length expected %0d, got %0d",
                   $time, want.seq_len, out_tdata[34:32]);
          fail_count++;
        end
        if (out_tdata[OUT_TDATA_W-1:35] !== '0) begin
          $display("%0t: tdata padding expected 0, got %h",
                   $time, out_tdata[OUT_TDATA_W-1:35]);
          fail_count++;
        end
        if (out_tuser !== want.err) begin
          $display("%0t: error flag expected %b, got %b", $time, want.err, out_tuser);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("utf8_sequence_validator_top verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_narrowed_second_bytes();
    test_bad_and_truncated();
    test_random_text(200);
    steady = 1'b1;
    test_random_text(100);
    steady = 1'b0;
    test_output_backpressure();
    test_random_text(120);
    in_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("utf8_sequence_validator_top verification clean");
    end else begin
      $display("utf8_sequence_validator_top verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/utf8v_pkg.sv
sv/utf8v_front.sv
sv/utf8v_queue.sv
sv/utf8v_back.sv
sv/utf8_sequence_validator_top.sv
tb/tb.sv
